// ===== rtl/mcg_pkg.sv =====
// Package: shared types and constants for the MIDI clock generator.
`timescale 1ns / 1ps

package mcg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_MODE = 2'd0,
    REG_BPM_PERIOD = 2'd1,
    REG_USB_GROUP  = 2'd2
  } cfg_reg_t;

  // Clock source selection
  typedef enum logic [1:0] {
    MODE_MASTER = 2'd0,
    MODE_SLAVE  = 2'd1,
    MODE_AUTO   = 2'd2
  } clock_mode_t;

  // Input request kinds
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // MIDI realtime status bytes
  localparam logic [7:0] MIDI_CLOCK    = 8'hf8;
  localparam logic [7:0] MIDI_START    = 8'hfa;
  localparam logic [7:0] MIDI_CONTINUE = 8'hfb;
  localparam logic [7:0] MIDI_STOP     = 8'hfc;

  // Pending transport flag bits
  localparam int FLAG_START = 0;
  localparam int FLAG_STOP  = 1;
  localparam int FLAG_CONT  = 2;

  // Reset values of the registers
  localparam logic [1:0]            RST_CLOCK_MODE = MODE_AUTO;
  localparam logic [CFG_DATA_W-1:0] RST_BPM_PERIOD = 30'd5208333;
  localparam logic [3:0]            RST_USB_GROUP  = 4'd1;

  // Counter limits and phase increment
  localparam logic [15:0] SLC_MAX      = 16'hffff;
  localparam logic [15:0] SLC_TIMEOUT  = 16'h0fff;
  localparam logic [31:0] PHASE_STEP   = 32'd1000000;
  localparam logic [7:0]  PENDING_MAX  = 8'hff;
  localparam logic [1:0]  INTERP_LAST  = 2'd3;
  localparam logic [2:0]  SIXTH_LAST   = 3'd5;

endpackage

// ===== rtl/midi_clock_master_slave_generator_top.sv =====
// Top level: MIDI clock generator, 24ppqn to 96ppqn with master/slave select.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one request per cycle while
//   in_ready is high: a tick, a received MIDI realtime byte with its source
//   port, or a tempo restart. Only a tick produces a result; it appears on
//   the out_ channel with the clock, start, stop and continue events, the
//   slave decision and the divide-by-6 / divide-by-24 counts. Bytes and
//   restarts produce nothing. A tick first sits in the input register, then
//   the state update loads the result register. Throughput is one request
//   per cycle while out_ready is high.
//   When the receiver stalls, the result waits in the output register;
//   the input register still drains bytes and restarts, while a tick waits
//   in the input register until the held result is taken (in_ready is low).
//   Configuration (cfg_we/cfg_index/cfg_wdata) is written while idle.
//   Synchronous reset (rst_n low) clears the valid flags and generator state
//   and loads the default registers: auto mode, 120 BPM period, USB group 1.
`timescale 1ns / 1ps

module midi_clock_master_slave_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [mcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [7:0]                    in_midi_byte,
  input  logic [7:0]                    in_source_port,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_clock_event,
  output logic                          out_start_event,
  output logic                          out_stop_event,
  output logic                          out_continue_event,
  output logic                          out_slave_active,
  output logic [2:0]                    out_sixth_count,
  output logic [1:0]                    out_quarter_count
);

  import mcg_pkg::*;

  // Configuration registers
  logic [1:0]            mode_r;
  logic [CFG_DATA_W-1:0] period_r;
  logic [3:0]            group_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_CLOCK_MODE;
      period_r <= RST_BPM_PERIOD;
      group_r  <= RST_USB_GROUP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLOCK_MODE: mode_r   <= cfg_wdata[1:0];
        REG_BPM_PERIOD: period_r <= cfg_wdata;
        REG_USB_GROUP:  group_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_op_r;
  logic [7:0] s1_byte_r;
  logic [7:0] s1_port_r;
  logic       s1_tick;
  logic       s1_go;
  logic       in_acc;

  assign s1_tick  = (op_t'(s1_op_r) == OP_TICK);
  assign s1_go    = s1_v_r && (!s1_tick || !out_valid || out_ready);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc)     s1_v_nxt = 1'b1;
    else if (s1_go) s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= s1_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_midi_byte;
      s1_port_r <= in_source_port;
    end
  end

  // Generator state
  logic [15:0] slc_r, slc_nxt;
  logic [15:0] mi_r, mi_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [1:0]  sent_r, sent_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        slave_r, slave_nxt;
  logic [2:0]  d6_r, d6_nxt;
  logic [1:0]  d4_r, d4_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic       o_clk_r, o_clk_nxt;
  logic       o_st_r, o_st_nxt;
  logic       o_sp_r, o_sp_nxt;
  logic       o_ct_r, o_ct_nxt;
  logic       o_slave_r;
  logic [2:0] o_d6_r;
  logic [1:0] o_d4_r;

  // Tick path intermediates
  logic [15:0] slc_inc;
  logic [15:0] delay_dec;
  logic        interp_fire;
  logic [7:0]  pend_after;
  logic [31:0] acc_sum;
  logic        clk_ev;
  logic [2:0]  d6_base;
  logic [1:0]  d4_base;
  // Byte path intermediates
  logic        port_filtered;
  logic [2:0]  req_n;
  logic [8:0]  req_sum;

  always_comb begin
    slc_nxt   = slc_r;
    mi_nxt    = mi_r;
    delay_nxt = delay_r;
    sent_nxt  = sent_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    slave_nxt = slave_r;
    d6_nxt    = d6_r;
    d4_nxt    = d4_r;
    o_clk_nxt = 1'b0;
    o_st_nxt  = 1'b0;
    o_sp_nxt  = 1'b0;
    o_ct_nxt  = 1'b0;

    // tick: counters, slave decision, interpolation, transport, clock
    slc_inc     = (slc_r == SLC_MAX) ? slc_r : slc_r + 16'd1;
    delay_dec   = delay_r - 16'd1;
    interp_fire = (delay_dec == 16'd0) && (sent_r < INTERP_LAST);
    pend_after  = (interp_fire && pend_r != PENDING_MAX) ? pend_r + 8'd1 : pend_r;
    acc_sum     = acc_r + PHASE_STEP;
    clk_ev      = 1'b0;
    d6_base     = flags_r[FLAG_START] ? 3'd0 : d6_r;
    d4_base     = flags_r[FLAG_START] ? 2'd0 : d4_r;

    // byte: port filter and clock request count
    port_filtered = (s1_port_r[7:4] == group_r) && (s1_port_r[3:0] != 4'd0);
    req_n         = 3'd4 - {1'b0, sent_r};
    req_sum       = {1'b0, pend_r} + {6'd0, req_n};

    if (s1_go) begin
      unique case (s1_op_r)
        OP_TICK: begin
          slc_nxt = slc_inc;
          unique case (mode_r)
            MODE_MASTER: slave_nxt = 1'b0;
            MODE_SLAVE:  slave_nxt = 1'b1;
            default:     slave_nxt = (slc_inc < SLC_TIMEOUT);
          endcase

          if (interp_fire) begin
            sent_nxt  = sent_r + 2'd1;
            delay_nxt = {2'b00, mi_r[15:2]};
          end else begin
            delay_nxt = delay_dec;
          end

          o_st_nxt  = flags_r[FLAG_START];
          o_sp_nxt  = flags_r[FLAG_STOP];
          o_ct_nxt  = flags_r[FLAG_CONT];
          flags_nxt = 3'b000;

          // consume a request, else run the phase accumulator in master
          pend_nxt = pend_after;
          if (pend_after != 8'd0) begin
            pend_nxt = pend_after - 8'd1;
            clk_ev   = slave_nxt;
          end else if (!slave_nxt) begin
            if (acc_sum > {2'b00, period_r}) begin
              acc_nxt = acc_sum - {2'b00, period_r};
              clk_ev  = 1'b1;
            end else begin
              acc_nxt = acc_sum;
            end
          end

          // clock dividers
          d6_nxt = d6_base;
          d4_nxt = d4_base;
          if (clk_ev) begin
            if (d6_base >= SIXTH_LAST) begin
              d6_nxt = 3'd0;
              d4_nxt = d4_base + 2'd1;
            end else begin
              d6_nxt = d6_base + 3'd1;
            end
          end
          o_clk_nxt = clk_ev;
        end
        OP_BYTE: begin
          if (!port_filtered) begin
            priority case (s1_byte_r)
              MIDI_CLOCK: begin
                mi_nxt    = slc_r;
                slc_nxt   = 16'd0;
                pend_nxt  = req_sum[8] ? PENDING_MAX : req_sum[7:0];
                sent_nxt  = 2'd0;
                delay_nxt = {2'b00, slc_r[15:2]};
              end
              MIDI_START: begin
                flags_nxt[FLAG_START] = 1'b1;
                if (slc_r > SLC_TIMEOUT) slc_nxt = 16'd0;
                pend_nxt = 8'd0;
                sent_nxt = INTERP_LAST;
              end
              MIDI_CONTINUE: flags_nxt[FLAG_CONT] = 1'b1;
              MIDI_STOP:     flags_nxt[FLAG_STOP] = 1'b1;
              default: ;
            endcase
          end
        end
        OP_RESTART: flags_nxt[FLAG_START] = 1'b1;
        default: ;
      endcase
    end

    // result register handshake
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_tick) out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slc_r       <= '0;
      mi_r        <= '0;
      delay_r     <= '0;
      sent_r      <= '0;
      pend_r      <= '0;
      acc_r       <= '0;
      flags_r     <= '0;
      slave_r     <= 1'b0;
      d6_r        <= '0;
      d4_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slc_r       <= slc_nxt;
      mi_r        <= mi_nxt;
      delay_r     <= delay_nxt;
      sent_r      <= sent_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      flags_r     <= flags_nxt;
      slave_r     <= slave_nxt;
      d6_r        <= d6_nxt;
      d4_r        <= d4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded when a tick leaves the input register
  always_ff @(posedge clk) begin
    if (s1_go && s1_tick) begin
      o_clk_r   <= o_clk_nxt;
      o_st_r    <= o_st_nxt;
      o_sp_r    <= o_sp_nxt;
      o_ct_r    <= o_ct_nxt;
      o_slave_r <= slave_nxt;
      o_d6_r    <= d6_nxt;
      o_d4_r    <= d4_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_clock_event    = o_clk_r;
  assign out_start_event    = o_st_r;
  assign out_stop_event     = o_sp_r;
  assign out_continue_event = o_ct_r;
  assign out_slave_active   = o_slave_r;
  assign out_sixth_count    = o_d6_r;
  assign out_quarter_count  = o_d4_r;

  // Checks

  // a start resets the dividers, so at most one clock is counted after it
  a_start_resets_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_event |-> out_quarter_count == 2'd0 && out_sixth_count <= 3'd1)
    else $error("dividers not reset on start");

  // divide-by-six count never leaves its range
  a_sixth_range: assert property (@(posedge clk) disable iff (!rst_n)
    d6_r <= SIXTH_LAST)
    else $error("sixth count out of range");

  // master mode never reports following the external clock
  a_master_not_slave: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_tick && mode_r == MODE_MASTER |=> !out_slave_active)
    else $error("slave active in master mode");

  // a tick held back by a stalled result stays in the input register
  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(s1_op_r))
    else $error("held request lost");

endmodule

// ===== tb/sv/tb_midi_clock_master_slave_generator_top.sv =====
// Testbench: self-checking stimulus, prediction and result checks for the MIDI clock generator.
`timescale 1ns / 1ps

module tb_midi_clock_master_slave_generator_top;
  import mcg_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int CLOCKS_PER_BYTE = 4;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] midi_byte;
    logic [7:0] port;
  } request_t;

  typedef struct packed {
    logic       clock_ev;
    logic       start_ev;
    logic       stop_ev;
    logic       cont_ev;
    logic       slave;
    logic [2:0] sixth;
    logic [1:0] quarter;
  } tick_result_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_op = OP_TICK;
  logic [7:0]            in_midi_byte = 8'h00;
  logic [7:0]            in_source_port = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_clock_event;
  logic                  out_start_event;
  logic                  out_stop_event;
  logic                  out_continue_event;
  logic                  out_slave_active;
  logic [2:0]            out_sixth_count;
  logic [1:0]            out_quarter_count;

  // Predicted generator state, reset values
  logic [1:0]  mode_reg        = RST_CLOCK_MODE;
  logic [29:0] period_reg      = RST_BPM_PERIOD;
  logic [3:0]  group_reg       = RST_USB_GROUP;
  logic [15:0] ticks_since_clk = '0;
  logic [15:0] clk_interval    = '0;
  logic [15:0] interp_wait     = '0;
  logic [1:0]  interp_done     = '0;
  logic [7:0]  owed_clocks     = '0;
  logic [31:0] phase_acc       = '0;
  logic [2:0]  transport_flags = '0;
  logic        following_ext   = 1'b0;
  logic [2:0]  six_div         = '0;
  logic [1:0]  four_div        = '0;

  request_t     request_queue[$];
  tick_result_t expected_ticks[$];
  tick_result_t observed;
  tick_result_t want;

  // Run control and bookkeeping
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_reqs      = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  int  cycle_count    = 0;
  int  error_count    = 0;
  int  accepted_count = 0;
  int  tick_count     = 0;
  int  checked_count  = 0;
  int  setting_count  = 1;
  bit  in_taken       = 1'b0;

  midi_clock_master_slave_generator_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_midi_byte      (in_midi_byte),
    .in_source_port    (in_source_port),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clock_event   (out_clock_event),
    .out_start_event   (out_start_event),
    .out_stop_event    (out_stop_event),
    .out_continue_event(out_continue_event),
    .out_slave_active  (out_slave_active),
    .out_sixth_count   (out_sixth_count),
    .out_quarter_count (out_quarter_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Slave clock requests, saturating at the counter limit
  function automatic void owe_clocks(int unsigned n);
    int unsigned sum;
    sum = int'(owed_clocks) + n;
    owed_clocks = (sum > int'(PENDING_MAX)) ? PENDING_MAX : 8'(sum);
  endfunction

  // Advance the predicted generator by one accepted request
  function automatic void advance_clock_model(request_t r);
    tick_result_t res;
    res = '0;
    case (r.op)
      OP_TICK: begin
        if (ticks_since_clk != SLC_MAX) ticks_since_clk++;
        case (mode_reg)
          MODE_MASTER: following_ext = 1'b0;
          MODE_SLAVE:  following_ext = 1'b1;
          default:     following_ext = (ticks_since_clk < SLC_TIMEOUT);
        endcase
        // interpolation countdown wraps at 16 bits
        interp_wait = interp_wait - 16'd1;
        if (interp_wait == 16'd0 && interp_done < INTERP_LAST) begin
          interp_done++;
          owe_clocks(1);
          interp_wait = clk_interval >> 2;
        end
        res.start_ev = transport_flags[FLAG_START];
        res.stop_ev  = transport_flags[FLAG_STOP];
        res.cont_ev  = transport_flags[FLAG_CONT];
        transport_flags = '0;
        if (res.start_ev) begin
          six_div  = '0;
          four_div = '0;
        end
        // a pending request is consumed even in master mode, without a clock
        if (owed_clocks != 8'd0) begin
          owed_clocks--;
          res.clock_ev = following_ext;
        end else if (!following_ext) begin
          phase_acc = phase_acc + PHASE_STEP;
          if (phase_acc > {2'b00, period_reg}) begin
            phase_acc = phase_acc - {2'b00, period_reg};
            res.clock_ev = 1'b1;
          end
        end
        if (res.clock_ev) begin
          if (six_div >= SIXTH_LAST) begin
            six_div = '0;
            four_div++;
          end else begin
            six_div++;
          end
        end
        res.slave   = following_ext;
        res.sixth   = six_div;
        res.quarter = four_div;
        expected_ticks.push_back(res);
      end
      OP_BYTE: begin
        // bytes from USB sub-ports are dropped
        if (!(r.port[7:4] == group_reg && r.port[3:0] != 4'h0)) begin
          case (r.midi_byte)
            MIDI_CLOCK: begin
              clk_interval    = ticks_since_clk;
              ticks_since_clk = '0;
              owe_clocks(CLOCKS_PER_BYTE - int'(interp_done));
              interp_done = '0;
              interp_wait = clk_interval >> 2;
            end
            MIDI_START: begin
              transport_flags[FLAG_START] = 1'b1;
              if (ticks_since_clk > SLC_TIMEOUT) ticks_since_clk = '0;
              owed_clocks = '0;
              interp_done = INTERP_LAST;
            end
            MIDI_CONTINUE: transport_flags[FLAG_CONT] = 1'b1;
            MIDI_STOP:     transport_flags[FLAG_STOP] = 1'b1;
            default: ;
          endcase
        end
      end
      OP_RESTART: transport_flags[FLAG_START] = 1'b1;
      default: ;
    endcase
  endfunction

  // Sender: next request at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_op          <= request_queue[0].op;
        in_midi_byte   <= request_queue[0].midi_byte;
        in_source_port <= request_queue[0].port;
        void'(request_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_ticks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && in_ready;
      if (rst_n && out_valid && out_ready) begin
        observed.clock_ev = out_clock_event;
        observed.start_ev = out_start_event;
        observed.stop_ev  = out_stop_event;
        observed.cont_ev  = out_continue_event;
        observed.slave    = out_slave_active;
        observed.sixth    = out_sixth_count;
        observed.quarter  = out_quarter_count;
        if (expected_ticks.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] result with no tick outstanding: %p", $realtime, observed);
        end else begin
          want = expected_ticks.pop_front();
          checked_count++;
          if (observed !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("[%0t] tick result mismatch", $realtime);
              $display("  expected clk=%0b start=%0b stop=%0b cont=%0b slave=%0b six=%0d qtr=%0d",
                       want.clock_ev, want.start_ev, want.stop_ev, want.cont_ev,
                       want.slave, want.sixth, want.quarter);
              $display("  actual   clk=%0b start=%0b stop=%0b cont=%0b slave=%0b six=%0d qtr=%0d",
                       observed.clock_ev, observed.start_ev, observed.stop_ev,
                       observed.cont_ev, observed.slave, observed.sixth, observed.quarter);
            end
          end
        end
      end
      if (in_taken) begin
        accepted_count++;
        if (in_op == OP_TICK) tick_count++;
        advance_clock_model('{op: in_op, midi_byte: in_midi_byte, port: in_source_port});
      end
    end
  end

  task automatic queue_request(logic [1:0] op, logic [7:0] b, logic [7:0] p);
    request_queue.push_back('{op: op, midi_byte: b, port: p});
  endtask

  // Random port that passes the USB sub-port filter
  function automatic logic [7:0] port_in_use();
    logic [7:0] p;
    p = 8'($urandom_range(0, 255));
    if (p[7:4] == group_reg) p[3:0] = 4'h0;
    return p;
  endfunction

  // Beat stream: ticks, then a clock byte; transport bytes and noise mixed in
  task automatic queue_beats(int beats, int max_gap);
    int gap;
    int pick;
    logic [7:0] b;
    repeat (beats) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_gap)
                                         : $urandom_range(1, max_gap);
      repeat (gap) begin
        queue_request(OP_TICK, 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          queue_request(OP_BYTE, MIDI_START, port_in_use());
        end else if (pick < 4) begin
          queue_request(OP_BYTE, MIDI_STOP, port_in_use());
        end else if (pick < 6) begin
          queue_request(OP_BYTE, MIDI_CONTINUE, port_in_use());
        end else if (pick < 7) begin
          queue_request(OP_RESTART, 8'($urandom), 8'($urandom));
        end else if (pick < 13) begin
          // noise: any op, any port, realtime or arbitrary byte
          case ($urandom_range(0, 4))
            0:       b = MIDI_CLOCK;
            1:       b = MIDI_START;
            2:       b = MIDI_CONTINUE;
            3:       b = MIDI_STOP;
            default: b = 8'($urandom);
          endcase
          queue_request(2'($urandom_range(0, 3)), b, 8'($urandom));
        end
      end
      queue_request(OP_BYTE, MIDI_CLOCK, port_in_use());
    end
  endtask

  // Wait until all requests are taken and all results checked
  task automatic wait_until_idle();
    while (request_queue.size() != 0 || in_valid || expected_ticks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CLOCK_MODE: mode_reg   = value[1:0];
      REG_BPM_PERIOD: period_reg = value;
      REG_USB_GROUP:  group_reg  = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [1:0] mode, logic [29:0] period, logic [3:0] group,
                           int idle, int stall);
    set_register(REG_CLOCK_MODE, 30'(mode));
    set_register(REG_BPM_PERIOD, period);
    set_register(REG_USB_GROUP, 30'(group));
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    setting_count++;
  endtask

  // Test sequence
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, filter, unknown bytes, unused op, transport flags
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_TICK, 8'hff, 8'hff);
    queue_request(OP_BYTE, MIDI_CLOCK, 8'h00);
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_BYTE, MIDI_CLOCK, 8'h11);
    queue_request(OP_BYTE, MIDI_CLOCK, 8'h10);
    queue_request(OP_BYTE, MIDI_CONTINUE, 8'hff);
    queue_request(OP_BYTE, MIDI_STOP, 8'h20);
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_BYTE, MIDI_START, 8'h0f);
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_BYTE, 8'h00, 8'h00);
    queue_request(OP_BYTE, 8'hff, 8'hf0);
    queue_request(OP_UNUSED, MIDI_CLOCK, 8'h00);
    queue_request(OP_UNUSED, 8'hff, 8'hff);
    queue_request(OP_RESTART, 8'h00, 8'h00);
    queue_request(OP_TICK, 8'h00, 8'h00);
    queue_request(OP_BYTE, MIDI_CONTINUE, 8'h00);
    queue_request(OP_TICK, 8'h00, 8'h00);
    repeat (5) queue_request(OP_TICK, 8'h00, 8'h00);
    wait_until_idle();

    // Auto mode, no idling: request saturation, then beats under a long hold-off
    configure(MODE_AUTO, RST_BPM_PERIOD, RST_USB_GROUP, 0, 0);
    repeat (70) queue_request(OP_BYTE, MIDI_CLOCK, 8'h00);
    repeat (300) queue_request(OP_TICK, 8'($urandom), 8'($urandom));
    queue_beats(15, 12);
    hold_reqs++;
    wait_until_idle();

    // Master at the shortest period, sparse sender
    configure(MODE_MASTER, 30'd1000000, 4'h0, 87, 0);
    queue_beats(20, 12);
    wait_until_idle();

    // Slave at the longest period, slow receiver
    configure(MODE_SLAVE, 30'd625000000, 4'hf, 0, 87);
    queue_beats(20, 12);
    wait_until_idle();

    // Unused mode code with a zero period, both sides idling
    configure(MODE_UNUSED, 30'd0, 4'($urandom), 36, 36);
    queue_beats(20, 12);
    wait_until_idle();

    // Random settings; the sender pauses for a full drain halfway
    repeat (2) begin
      configure(2'($urandom_range(0, 3)), 30'($urandom_range(1000000, 625000000)),
                4'($urandom), 36, 36);
      queue_beats(12, 12);
      wait_until_idle();
      queue_beats(12, 12);
      wait_until_idle();
    end

    $display("Run covered %0d requests (%0d ticks) across %0d register settings,",
             accepted_count, tick_count, setting_count);
    $display("all clock modes, idle/stall mixes and a held-off receiver; %0d results checked.",
             checked_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
